>>> rtl/core/bsn_pkg.sv
// Package for the membership bitmap with next-member iterator.
// Holds sizes, command/status codes, transfer structs and the FSM state type.
// No dependencies.
package bsn_pkg;

    // Set geometry
    localparam int SET_CAPACITY = 1024;
    localparam int WORD_BITS    = 64;
    localparam int WORD_COUNT   = (SET_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int POS_W        = $clog2(SET_CAPACITY);
    localparam int START_W      = POS_W + 1;
    localparam int FOUND_W      = WORD_W + BIT_W;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int ELEMENT_W = 11;
    localparam int STATUS_W  = 2;
    localparam int NEXT_W    = 10;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_CONTAINS   = 3'd3,
        CMD_ITER_BEGIN = 3'd4,
        CMD_ITER_NEXT  = 3'd5
    } bsn_cmd_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_ABSENT = 2'd2
    } bsn_status_t;

    // Control FSM
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_FINISH
    } bsn_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [ELEMENT_W-1:0] element;
    } bsn_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_member;
        logic [NEXT_W-1:0]   next_element;
        logic                next_valid;
    } bsn_result_t;

    // Word store access from the controller
    typedef struct packed {
        logic                 rd_en;
        logic [WORD_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [WORD_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clear_all;
    } bsn_store_req_t;

    // Index of the lowest set bit; 0 for an all-zero word
    function automatic logic [BIT_W-1:0] low_bit_index(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/core/bsn_word_store.sv
// Bitmap word memory with a registered read port and one write port.
// Per-word valid flops give all-zero contents after reset and after clear.
// Depends on bsn_pkg.
module bsn_word_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsn_pkg::bsn_store_req_t        req,
    output logic [bsn_pkg::WORD_BITS-1:0]  rd_data
);
    import bsn_pkg::*;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] word_valid_reg;
    logic [WORD_BITS-1:0] rd_raw_reg;
    logic                 rd_valid_reg;

    // Memory array: write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    // Valid bits: a word never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (req.clear_all) begin
                word_valid_reg <= '0;
            end else if (req.wr_en) begin
                word_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= word_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

>>> rtl/core/bitmap_set_with_next_iterator_top.sv
// Membership bitmap of SET_CAPACITY elements with a forward iteration cursor.
// Top level: command FSM and read-modify-write datapath around bsn_word_store.
// Depends on bsn_pkg and bsn_word_store.
//
// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it, and the next command may be started in the same cycle that done is
// high. Add, remove and contains read one word, then give the write-back or
// result; clear needs no word read.
// Iterate begin and iterate next scan the 64-bit words from the cursor to the
// next member, one word read per cycle through the single read port of the store.
// An iterate next whose cursor sits on the last element scans no word.
// Clear takes effect at once through per-word valid bits, with no sweep.
module bitmap_set_with_next_iterator_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bsn_pkg::bsn_request_t request,
    output logic                  done,
    output bsn_pkg::bsn_result_t  result
);
    import bsn_pkg::*;

    bsn_state_t           state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ELEMENT_W-1:0] element_reg, element_next;
    logic [POS_W-1:0]     cursor_pos_reg, cursor_pos_next;
    logic                 cursor_valid_reg, cursor_valid_next;
    logic [WORD_W-1:0]    scan_word_reg, scan_word_next;
    logic [BIT_W-1:0]     scan_bit_reg, scan_bit_next;
    logic                 done_reg, done_next;
    bsn_result_t          result_reg, result_next;

    bsn_store_req_t       store_req;
    logic [WORD_BITS-1:0] word_data;

    // Request decode in the accepting cycle
    logic                 req_in_range;
    logic [WORD_W-1:0]    req_word;
    logic [START_W-1:0]   iter_start;
    logic                 iter_start_ok;

    // Datapath on the word read back
    logic                 elem_bit;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] scan_masked;
    logic [FOUND_W-1:0]   found_idx;
    logic                 found_ok;
    logic                 last_word;

    bsn_word_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (word_data)
    );

    // Request decode
    always_comb
    begin
        req_in_range  = 32'(request.element) < SET_CAPACITY;
        req_word      = WORD_W'(32'(request.element) >> BIT_W);
        if (request.cmd == CMD_ITER_BEGIN || !cursor_valid_reg) begin
            iter_start = '0;
        end else begin
            iter_start = {1'b0, cursor_pos_reg} + START_W'(1);
        end
        iter_start_ok = (32'(iter_start) >> BIT_W) < WORD_COUNT;
    end

    // Word datapath
    always_comb
    begin
        bit_mask    = WORD_BITS'(1) << element_reg[BIT_W-1:0];
        elem_bit    = (word_data & bit_mask) != '0;
        scan_masked = word_data & ({WORD_BITS{1'b1}} << scan_bit_reg);
        found_idx   = {scan_word_reg, low_bit_index(scan_masked)};
        found_ok    = 32'(found_idx) < SET_CAPACITY;
        last_word   = scan_word_reg == WORD_W'(WORD_COUNT - 1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    case (request.cmd) inside
                        CMD_ADD, CMD_REMOVE, CMD_CONTAINS:
                            state_next = req_in_range ? ST_ACCESS : ST_FINISH;
                        CMD_ITER_BEGIN, CMD_ITER_NEXT:
                            state_next = iter_start_ok ? ST_SCAN : ST_FINISH;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ACCESS:
                state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (scan_masked != '0 || last_word) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath registers
    always_comb
    begin
        cmd_next          = cmd_reg;
        element_next      = element_reg;
        cursor_pos_next   = cursor_pos_reg;
        cursor_valid_next = cursor_valid_reg;
        scan_word_next    = scan_word_reg;
        scan_bit_next     = scan_bit_reg;
        done_next         = 1'b0;
        result_next       = result_reg;
        store_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    cmd_next          = request.cmd;
                    element_next      = request.element;
                    scan_word_next    = WORD_W'(iter_start >> BIT_W);
                    scan_bit_next     = iter_start[BIT_W-1:0];
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = (request.cmd == CMD_ITER_BEGIN ||
                                         request.cmd == CMD_ITER_NEXT)
                                        ? WORD_W'(iter_start >> BIT_W) : req_word;
                end
            end
            // Single-word read-modify-write; write lands before the next read
            ST_ACCESS:
            begin
                done_next         = 1'b1;
                result_next       = '0;
                store_req.wr_addr = WORD_W'(32'(element_reg) >> BIT_W);
                case (cmd_reg) inside
                    CMD_ADD:
                    begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_data = word_data | bit_mask;
                    end
                    CMD_REMOVE:
                    begin
                        if (elem_bit) begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_data = word_data & ~bit_mask;
                        end else begin
                            result_next.status = STATUS_ABSENT;
                        end
                    end
                    CMD_CONTAINS:
                        result_next.is_member = elem_bit;
                    default:
                        result_next = '0;
                endcase
            end
            // One word per cycle until a member or the end of the set
            ST_SCAN:
            begin
                if (scan_masked != '0 || last_word) begin
                    done_next   = 1'b1;
                    result_next = '0;
                    if (scan_masked != '0 && found_ok) begin
                        cursor_pos_next          = POS_W'(found_idx);
                        cursor_valid_next        = 1'b1;
                        result_next.next_element = NEXT_W'(found_idx);
                        result_next.next_valid   = 1'b1;
                    end else begin
                        cursor_pos_next   = '0;
                        cursor_valid_next = 1'b0;
                    end
                end else begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = scan_word_reg + WORD_W'(1);
                    scan_word_next    = scan_word_reg + WORD_W'(1);
                    scan_bit_next     = '0;
                end
            end
            // Commands that need no word read
            ST_FINISH:
            begin
                done_next   = 1'b1;
                result_next = '0;
                case (cmd_reg) inside
                    CMD_CLEAR:
                    begin
                        store_req.clear_all = 1'b1;
                        cursor_pos_next     = '0;
                        cursor_valid_next   = 1'b0;
                    end
                    CMD_ADD, CMD_REMOVE:
                        result_next.status = STATUS_RANGE;
                    CMD_ITER_BEGIN, CMD_ITER_NEXT:
                    begin
                        cursor_pos_next   = '0;
                        cursor_valid_next = 1'b0;
                    end
                    default:
                        result_next = '0;
                endcase
            end
            default:
                result_next = result_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            cursor_pos_reg   <= '0;
            cursor_valid_reg <= 1'b0;
            done_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cursor_pos_reg   <= cursor_pos_next;
            cursor_valid_reg <= cursor_valid_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        element_reg   <= element_next;
        scan_word_reg <= scan_word_next;
        scan_bit_reg  <= scan_bit_next;
        result_reg    <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results on consecutive cycles");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in flight");

    a_found_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.next_valid |-> result.status == STATUS_OK && !result.is_member)
        else $error("iterate hit carries a status or membership flag");

    a_cursor_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.next_valid |-> cursor_valid_reg)
        else $error("iterate hit left the cursor invalid");

endmodule
